// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

   // field widths fixed by the port list
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int TAB_W  = 2;

   // default screen geometry
   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 25;

   // control characters
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd112;
   localparam logic [TAB_W-1:0]  TAB_SPACES = 2'd3;

   // request opcodes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic put;
      logic newline;
      logic cret;
      logic scroll_step;
      logic read;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scroll_last;
      logic op_read;
      logic is_newline;
      logic is_return;
      logic col_last;
      logic row_last;
      logic in_range;
      logic put_more;
      logic put_pending;
      logic rsp_free;
   } ctrl_status_type;

endpackage

// ----- rtl/tcw_ctrl.sv -----
module tcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tcw_pkg::ctrl_status_type status,
   output tcw_pkg::ctrl_cmd_type    cmd
);

   tcw_pkg::state_type state_ff;
   tcw_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            if (status.op_read || status.is_return) begin
               state_in = tcw_pkg::ST_DONE;
            end else if (status.is_newline) begin
               state_in = status.row_last ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
            end else if (status.col_last && status.row_last) begin
               state_in = tcw_pkg::ST_SCROLL;
            end else if (!status.put_more) begin
               state_in = tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            if (status.scroll_last) begin
               state_in = status.put_pending ? tcw_pkg::ST_EXEC : tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         tcw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         tcw_pkg::ST_EXEC: begin
            if (status.op_read) begin
               cmd.read = status.in_range;
            end else if (status.is_newline) begin
               cmd.newline = 1'b1;
            end else if (status.is_return) begin
               cmd.cret = 1'b1;
            end else begin
               cmd.put = 1'b1;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
         end
         tcw_pkg::ST_DONE: begin
            cmd.finish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/tcw_datapath.sv -----
module tcw_datapath #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]   csr_text_attr,
   input  logic                         req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]    req_read_col,
   input  logic [tcw_pkg::ROW_W-1:0]    req_read_row,
   input  tcw_pkg::ctrl_cmd_type        cmd,
   output tcw_pkg::ctrl_status_type     status,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]   rsp_cell_value,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int COL_W = tcw_pkg::COL_W;
   localparam int ROW_W = tcw_pkg::ROW_W;
   localparam int CELL_W = tcw_pkg::CELL_W;
   localparam int TAB_W = tcw_pkg::TAB_W;

   // cell store
   logic [CELL_W-1:0] cells_ff [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   // control registers
   logic [tcw_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] base_ff, base_in;
   logic [ROW_W-1:0] fill_ff, fill_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic [TAB_W-1:0] tabs_ff, tabs_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // latched request
   logic                       op_ff;
   logic [tcw_pkg::CHAR_W-1:0] char_ff;
   logic [COL_W-1:0]           rcol_ff;
   logic [ROW_W-1:0]           rrow_ff;

   // response payload
   logic [CELL_W-1:0] cell_ff;
   logic [COL_W-1:0]  ocol_ff;
   logic [ROW_W-1:0]  orow_ff;

   logic             col_last, row_last, line_feed;
   logic             is_newline, is_return, is_tab, in_range;
   logic [ROW_W-1:0] lrow, prow, arow;
   logic [COL_W-1:0] lcol, acol;
   logic [ROW_W:0]   rsum;
   logic [AW-1:0]    addr;
   logic             we;
   logic [CELL_W-1:0] wdata;
   logic [tcw_pkg::CHAR_W-1:0] put_char;

   // request decode
   assign col_last   = (col_ff == COL_W'(COLS - 1));
   assign row_last   = (row_ff == ROW_W'(ROWS - 1));
   assign is_newline = (char_ff == tcw_pkg::CH_NEWLINE);
   assign is_return  = (char_ff == tcw_pkg::CH_RETURN);
   assign is_tab     = (char_ff == tcw_pkg::CH_TAB);
   assign in_range   = ({1'b0, rcol_ff} < (COL_W + 1)'(COLS))
                    && ({1'b0, rrow_ff} < (ROW_W + 1)'(ROWS));
   assign put_char   = is_tab ? tcw_pkg::CH_SPACE : char_ff;

   // status to the controller
   assign status.clear_last  = (sweep_ff == AW'(CELLS - 1));
   assign status.scroll_last = (sweep_ff == AW'(COLS - 1));
   assign status.op_read     = (op_ff == tcw_pkg::OP_READ);
   assign status.is_newline  = is_newline;
   assign status.is_return   = is_return;
   assign status.col_last    = col_last;
   assign status.row_last    = row_last;
   assign status.in_range    = in_range;
   assign status.put_more    = (tabs_ff > TAB_W'(1));
   assign status.put_pending = (tabs_ff != '0);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   // store address: logical row rotated by the scroll base, or the sweep during clear and scroll
   always_comb begin
      lrow = cmd.read ? rrow_ff : row_ff;
      lcol = cmd.read ? rcol_ff : col_ff;
      rsum = (ROW_W + 1)'(lrow) + (ROW_W + 1)'(base_ff);
      prow = (rsum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(rsum - (ROW_W + 1)'(ROWS))
                                          : ROW_W'(rsum);
      arow = cmd.scroll_step ? fill_ff : prow;
      acol = cmd.scroll_step ? COL_W'(sweep_ff) : lcol;
      if (cmd.clr_step) begin
         addr = sweep_ff;
      end else begin
         addr = AW'(AW'(arow) * AW'(COLS)) + AW'(acol);
      end
   end

   // store write data
   always_comb begin
      we    = cmd.clr_step || cmd.scroll_step || cmd.put;
      wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
      if (cmd.scroll_step) begin
         wdata = {attr_ff, tcw_pkg::CH_SPACE};
      end else if (cmd.put) begin
         wdata = {attr_ff, put_char};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         cells_ff[addr] <= wdata;
      end
      if (cmd.read) begin
         rdata_ff <= cells_ff[addr];
      end
   end

   // cursor, scroll base and sweep counter
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      base_in   = base_ff;
      fill_in   = fill_ff;
      sweep_in  = sweep_ff;
      tabs_in   = tabs_ff;
      line_feed = 1'b0;
      if (cmd.load) begin
         if (req_op == tcw_pkg::OP_READ || req_char_code == tcw_pkg::CH_NEWLINE
             || req_char_code == tcw_pkg::CH_RETURN) begin
            tabs_in = '0;
         end else if (req_char_code == tcw_pkg::CH_TAB) begin
            tabs_in = tcw_pkg::TAB_SPACES;
         end else begin
            tabs_in = TAB_W'(1);
         end
      end
      if (cmd.clr_step || cmd.scroll_step) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (cmd.put) begin
         tabs_in = tabs_ff - 1'b1;
         if (col_last) begin
            line_feed = 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (cmd.newline) begin
         line_feed = 1'b1;
      end
      if (cmd.cret) begin
         col_in = '0;
      end
      if (line_feed) begin
         col_in = '0;
         if (row_last) begin
            base_in  = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + 1'b1;
            fill_in  = base_ff;
            sweep_in = '0;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   // attribute register and response valid
   always_comb begin
      attr_in = csr_valid ? csr_text_attr : attr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tcw_pkg::ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         fill_ff      <= '0;
         sweep_ff     <= '0;
         tabs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         sweep_ff     <= sweep_in;
         tabs_ff      <= tabs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         char_ff <= req_char_code;
         rcol_ff <= req_read_col;
         rrow_ff <= req_read_row;
      end
      if (cmd.finish) begin
         cell_ff <= (status.op_read && in_range) ? rdata_ff : '0;
         ocol_ff <= col_ff;
         orow_ff <= row_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = cell_ff;
   assign rsp_cursor_col = ocol_ff;
   assign rsp_cursor_row = orow_ff;

endmodule

// ----- rtl/text_console_writer.sv -----
// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     op, char_code, read_col, read_row
// rsp_      out        rsp_valid / rsp_stall     cell_value, cursor_col, cursor_row
// csr_      in         csr_valid / csr_ready     text_attr
//
// a read, a return, a newline or a plain character goes from IDLE through EXEC to DONE,
// a tab stays in EXEC to put three spaces, and a newline or a wrap on the last row adds a
// SCROLL pass that blanks the bottom row. the cell store has one port, so cell
// writes and reads are done one at a time. after reset a clearing pass writes blanks
// into the COLS*ROWS cells; req_stall stays high meanwhile while csr writes are taken.
// a held response keeps its register, so one more request is taken under rsp_stall.
module text_console_writer #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]    req_read_col,
   input  logic [tcw_pkg::ROW_W-1:0]    req_read_row,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]   rsp_cell_value,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]   csr_text_attr
);

   tcw_pkg::ctrl_cmd_type    cmd;
   tcw_pkg::ctrl_status_type status;

   // attribute register takes a write in any cycle
   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_text_attr  (csr_text_attr),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_read_col   (req_read_col),
      .req_read_row   (req_read_row),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

endmodule

// ----- rtl/tcw_checker.sv -----
module tcw_checker #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [tcw_pkg::CELL_W-1:0] rsp_cell_value,
   input logic [tcw_pkg::COL_W-1:0]  rsp_cursor_col,
   input logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row
);

   // a held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value)
         && $stable(rsp_cursor_col) && $stable(rsp_cursor_row))
      else $error("response changed while stalled");

   // the store clear keeps requests out right after reset
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // one request at a time: busy after each accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken back to back");

   // reported cursor always lies on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_cursor_col} < (tcw_pkg::COL_W + 1)'(COLS))
         && ({1'b0, rsp_cursor_row} < (tcw_pkg::ROW_W + 1)'(ROWS)))
      else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcw_checker (.*);
